>>> src/nco_pkg.sv
`default_nettype none

package nco_pkg;

    localparam int PHASE_BITS       = 32;
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int SAMPLE_BITS      = 16;

    localparam int FREQ_BITS  = 25;
    localparam int RATE_BITS  = 18;
    localparam int COUNT_BITS = 32;
    localparam int HALF_BITS  = RATE_BITS + 7;
    localparam int DVS_BITS   = 32;
    localparam int QUO_BITS   = (PHASE_BITS > 32) ? PHASE_BITS : 32;
    localparam int DVD_BITS   = FREQ_BITS + QUO_BITS;
    localparam int ITER_BITS  = $clog2(DVD_BITS + 1);

    localparam int ITERS_STEP   = FREQ_BITS + PHASE_BITS;
    localparam int ITERS_PERIOD = HALF_BITS;
    localparam int ITERS_MOD    = COUNT_BITS;

    localparam logic [RATE_BITS-1:0] RATE_RESET = RATE_BITS'(44100);

    localparam int SINE_BITS    = $clog2(SINE_TABLE_DEPTH);
    localparam int QUARTER      = SINE_TABLE_DEPTH / 4;
    localparam int QUARTER_BITS = SINE_BITS - 2;
    localparam int TRI_SHIFT    = 31 - SAMPLE_BITS;
    localparam int SAW_SHIFT    = 32 - SAMPLE_BITS;
    localparam int U_SHIFT_UP   = (PHASE_BITS >= 32) ? 0 : 32 - PHASE_BITS;
    localparam int U_SHIFT_DN   = (PHASE_BITS >= 32) ? PHASE_BITS - 32 : 0;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX =
        {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN =
        {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [1:0] {
        FUNC_SINE     = 2'd0,
        FUNC_SQUARE   = 2'd1,
        FUNC_TRIANGLE = 2'd2,
        FUNC_SAW      = 2'd3
    } t_func;

    typedef struct packed {
        logic                 start;
        logic [DVD_BITS-1:0]  dividend;
        logic [DVS_BITS-1:0]  divisor;
        logic [ITER_BITS-1:0] iters;
    } t_div_cmd;

    typedef struct packed {
        logic                done;
        logic [QUO_BITS-1:0] quot;
        logic [DVS_BITS-1:0] rem;
    } t_div_stat;

    typedef logic [SAMPLE_BITS-2:0] t_sine_table [QUARTER];

    // Restoring long division, one quotient bit per step, used only at elaboration.
    function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Quarter-wave sine in Q30 by a truncating Taylor series, evaluated at elaboration.
    function automatic logic [63:0] quarter_sine_q30(input logic [63:0] w);
        logic [63:0] x;
        logic [63:0] sum;
        logic [63:0] term;
        logic [63:0] den;
        for (int n = 1; n <= 8; n++) begin
            if (n == 1) begin
                x    = (w * HALF_PI_Q30) >> 30;
                sum  = x;
                term = x;
            end
            den  = 64'((2 * n) * (2 * n + 1));
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = div_u64(term, den);
            if ((n & 1) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        return sum;
    endfunction

    function automatic logic [SAMPLE_BITS-2:0] sine_mag(input int k);
        logic [63:0] s;
        logic [63:0] mag;
        logic [63:0] fs;
        fs  = 64'd1 << (SAMPLE_BITS - 1);
        s   = quarter_sine_q30(64'(k) << (30 - QUARTER_BITS));
        mag = (s * fs + (64'd1 << 29)) >> 30;
        if (mag > fs - 64'd1) begin
            mag = fs - 64'd1;
        end
        return mag[SAMPLE_BITS-2:0];
    endfunction

    function automatic t_sine_table build_sine_table();
        t_sine_table tbl;
        for (int k = 0; k < QUARTER; k++) begin
            tbl[k] = sine_mag(k);
        end
        return tbl;
    endfunction

    localparam t_sine_table SINE_TABLE = build_sine_table();
    localparam logic [SAMPLE_BITS-2:0] SINE_PEAK = sine_mag(QUARTER);

endpackage

`default_nettype wire

>>> src/phase_accumulator_waveform_oscillator_core.sv
// Audio oscillator that returns one signed sample for each request.
// A request on the input channel (i_in_valid, o_in_stall) carries a waveform
// select and a frequency in 1/256 Hz. The sample leaves on the output channel
// (o_out_valid, i_out_stall) together with the over_nyquist flag.
// The sample rate register is written through i_cfg_we and i_cfg_data; the
// user must write it only while the block is idle, as the block does not enforce it.
// One restoring divider, one quotient bit per cycle, does all the work.
// Sine, triangle and sawtooth requests run a phase step division; the
// new phase is then shaped into a registered sample.
// Square requests run a period division and then a modulo of the sample
// count; at zero frequency the first division is skipped.
// A new request is taken only when the previous one has finished, that is,
// once its sample has moved into the output register.
// The result waits in an output register while the receiver stalls; the next
// request may be accepted meanwhile and finishes once that register is free.
// Reset clears the phase and the sample count, sets the square level high
// and loads a sample rate of 44100 Hz.
`default_nettype none

module phase_accumulator_waveform_oscillator_core
    import nco_pkg::*;
(
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [RATE_BITS-1:0]         i_cfg_data,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [1:0]                   i_func,
    input  wire logic [FREQ_BITS-1:0]         i_frequency,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic signed [SAMPLE_BITS-1:0]     o_sample,
    output logic                              o_over_nyquist
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_STEP   = 6'b000010,
        S_SHAPE  = 6'b000100,
        S_PERIOD = 6'b001000,
        S_MOD    = 6'b010000,
        S_OUT    = 6'b100000
    } t_state;

    t_state                         r_state;
    t_state                         n_state;
    logic [RATE_BITS-1:0]           r_rate;
    logic [RATE_BITS-1:0]           n_rate;
    logic [1:0]                     r_func;
    logic [1:0]                     n_func;
    logic [PHASE_BITS-1:0]          r_phase;
    logic [PHASE_BITS-1:0]          n_phase;
    logic [COUNT_BITS-1:0]          r_count;
    logic [COUNT_BITS-1:0]          n_count;
    logic                           r_level;
    logic                           n_level;
    logic signed [SAMPLE_BITS-1:0]  r_res_sample;
    logic signed [SAMPLE_BITS-1:0]  n_res_sample;
    logic                           r_res_flag;
    logic                           n_res_flag;
    logic                           r_out_valid;
    logic                           n_out_valid;
    logic signed [SAMPLE_BITS-1:0]  r_out_sample;
    logic signed [SAMPLE_BITS-1:0]  n_out_sample;
    logic                           r_out_flag;
    logic                           n_out_flag;

    t_div_cmd                       div_cmd;
    t_div_stat                      div_stat;
    logic signed [SAMPLE_BITS-1:0]  shape_sample;
    logic                           in_accept;
    logic                           out_free;
    logic [HALF_BITS-1:0]           half;
    logic [RATE_BITS+7:0]           den;
    logic [DVS_BITS-1:0]            period;

    nco_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (div_cmd),
        .o_stat  (div_stat)
    );

    nco_shape u_shape (
        .i_func   (r_func),
        .i_phase  (r_phase),
        .o_sample (shape_sample)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && (r_state == S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;

    always_comb begin
        half   = {r_rate, 7'b0};
        den    = (r_rate == '0) ? (RATE_BITS + 8)'(256) : {r_rate, 8'b0};
        period = div_stat.quot[DVS_BITS-1:0];
        if (period == '0) begin
            period = DVS_BITS'(1);
        end

        n_state      = r_state;
        n_rate       = i_cfg_we ? i_cfg_data : r_rate;
        n_func       = r_func;
        n_phase      = r_phase;
        n_count      = r_count;
        n_level      = r_level;
        n_res_sample = r_res_sample;
        n_res_flag   = r_res_flag;
        n_out_valid  = r_out_valid;
        n_out_sample = r_out_sample;
        n_out_flag   = r_out_flag;

        div_cmd = '0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_func       = i_func;
                    n_res_flag   = 1'b0;
                    div_cmd.start = 1'b1;
                    if (t_func'(i_func) == FUNC_SQUARE) begin
                        if (i_frequency == '0) begin
                            div_cmd.dividend = DVD_BITS'(r_count) << (DVD_BITS - COUNT_BITS);
                            div_cmd.divisor  = '1;
                            div_cmd.iters    = ITER_BITS'(ITERS_MOD);
                            n_state          = S_MOD;
                        end else begin
                            div_cmd.dividend = DVD_BITS'(half) << (DVD_BITS - HALF_BITS);
                            div_cmd.divisor  = DVS_BITS'(i_frequency);
                            div_cmd.iters    = ITER_BITS'(ITERS_PERIOD);
                            n_state          = S_PERIOD;
                        end
                    end else begin
                        div_cmd.dividend = DVD_BITS'(i_frequency) << (DVD_BITS - FREQ_BITS);
                        div_cmd.divisor  = DVS_BITS'(den);
                        div_cmd.iters    = ITER_BITS'(ITERS_STEP);
                        n_state          = S_STEP;
                    end
                end
            end
            S_STEP: begin
                if (div_stat.done) begin
                    n_phase = r_phase + div_stat.quot[PHASE_BITS-1:0];
                    n_state = S_SHAPE;
                end
            end
            S_SHAPE: begin
                n_res_sample = shape_sample;
                n_state      = S_OUT;
            end
            S_PERIOD: begin
                if (div_stat.done) begin
                    n_res_flag       = (div_stat.quot[DVS_BITS-1:0] == '0);
                    div_cmd.start    = 1'b1;
                    div_cmd.dividend = DVD_BITS'(r_count) << (DVD_BITS - COUNT_BITS);
                    div_cmd.divisor  = period;
                    div_cmd.iters    = ITER_BITS'(ITERS_MOD);
                    n_state          = S_MOD;
                end
            end
            S_MOD: begin
                if (div_stat.done) begin
                    n_level      = (div_stat.rem == '0) ? !r_level : r_level;
                    n_count      = r_count + COUNT_BITS'(1);
                    n_res_sample = n_level ? SAMPLE_MAX : SAMPLE_MIN;
                    n_state      = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_sample = r_res_sample;
                    n_out_flag   = r_res_flag;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rate      <= RATE_RESET;
            r_phase     <= '0;
            r_count     <= '0;
            r_level     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rate      <= n_rate;
            r_phase     <= n_phase;
            r_count     <= n_count;
            r_level     <= n_level;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func       <= n_func;
        r_res_sample <= n_res_sample;
        r_res_flag   <= n_res_flag;
        r_out_sample <= n_out_sample;
        r_out_flag   <= n_out_flag;
    end

    assign o_out_valid    = r_out_valid;
    assign o_sample       = r_out_sample;
    assign o_over_nyquist = r_out_flag;

endmodule

`default_nettype wire

>>> src/nco_div.sv
`default_nettype none

module nco_div
    import nco_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_div_cmd  i_cmd,
    output t_div_stat      o_stat
);

    logic                 r_busy;
    logic                 n_busy;
    logic                 r_done;
    logic                 n_done;
    logic [ITER_BITS-1:0] r_cnt;
    logic [ITER_BITS-1:0] n_cnt;
    logic [DVD_BITS-1:0]  r_dvd;
    logic [DVD_BITS-1:0]  n_dvd;
    logic [DVS_BITS-1:0]  r_dvs;
    logic [DVS_BITS-1:0]  n_dvs;
    logic [QUO_BITS-1:0]  r_quo;
    logic [QUO_BITS-1:0]  n_quo;
    logic [DVS_BITS-1:0]  r_rem;
    logic [DVS_BITS-1:0]  n_rem;

    logic [DVS_BITS:0] trial;
    logic [DVS_BITS:0] diff;
    logic              fits;

    always_comb begin
        trial = {r_rem, r_dvd[DVD_BITS-1]};
        diff  = trial - {1'b0, r_dvs};
        fits  = (trial >= {1'b0, r_dvs});

        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_dvs  = r_dvs;
        n_quo  = r_quo;
        n_rem  = r_rem;

        if (i_cmd.start) begin
            n_busy = 1'b1;
            n_cnt  = i_cmd.iters;
            n_dvd  = i_cmd.dividend;
            n_dvs  = i_cmd.divisor;
            n_quo  = '0;
            n_rem  = '0;
        end else if (r_busy) begin
            n_dvd = {r_dvd[DVD_BITS-2:0], 1'b0};
            n_quo = {r_quo[QUO_BITS-2:0], fits};
            n_rem = fits ? diff[DVS_BITS-1:0] : trial[DVS_BITS-1:0];
            n_cnt = r_cnt - ITER_BITS'(1);
            if (r_cnt == ITER_BITS'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dvd <= n_dvd;
        r_dvs <= n_dvs;
        r_quo <= n_quo;
        r_rem <= n_rem;
    end

    assign o_stat.done = r_done;
    assign o_stat.quot = r_quo;
    assign o_stat.rem  = r_rem;

endmodule

`default_nettype wire

>>> src/nco_shape.sv
`default_nettype none

module nco_shape
    import nco_pkg::*;
(
    input  wire logic [1:0]                    i_func,
    input  wire logic [PHASE_BITS-1:0]         i_phase,
    output logic signed [SAMPLE_BITS-1:0]      o_sample
);

    logic [31:0]                u;
    logic [SINE_BITS-1:0]       idx;
    logic [1:0]                 quad;
    logic [QUARTER_BITS-1:0]    j;
    logic [QUARTER_BITS-1:0]    k;
    logic [SAMPLE_BITS-2:0]     mag;
    logic [SAMPLE_BITS-1:0]     sine_val;
    logic [31:0]                d;
    logic [SAMPLE_BITS+1:0]     tri_val;
    logic [SAMPLE_BITS-1:0]     saw_raw;

    always_comb begin
        u = 32'((64'(i_phase) << U_SHIFT_UP) >> U_SHIFT_DN);

        idx  = u[31 -: SINE_BITS];
        quad = idx[SINE_BITS-1 -: 2];
        j    = idx[QUARTER_BITS-1:0];
        k    = quad[0] ? (QUARTER_BITS'(0) - j) : j;
        if (quad[0] && (j == '0)) begin
            mag = SINE_PEAK;
        end else begin
            mag = SINE_TABLE[k];
        end
        sine_val = quad[1] ? (SAMPLE_BITS'(0) - SAMPLE_BITS'(mag)) : SAMPLE_BITS'(mag);

        d = u[31] ? {1'b0, u[30:0]} : (32'h8000_0000 - u);
        tri_val = ((SAMPLE_BITS + 2)'(1) << (SAMPLE_BITS - 1))
                - (SAMPLE_BITS + 2)'(d >> TRI_SHIFT);

        saw_raw = SAMPLE_BITS'(u >> SAW_SHIFT);

        case (t_func'(i_func))
            FUNC_SINE: begin
                o_sample = sine_val;
            end
            FUNC_TRIANGLE: begin
                if (tri_val == ((SAMPLE_BITS + 2)'(1) << (SAMPLE_BITS - 1))) begin
                    o_sample = SAMPLE_MAX;
                end else begin
                    o_sample = tri_val[SAMPLE_BITS-1:0];
                end
            end
            FUNC_SAW: begin
                o_sample = {~saw_raw[SAMPLE_BITS-1], saw_raw[SAMPLE_BITS-2:0]};
            end
            default: begin
                o_sample = SAMPLE_MAX;
            end
        endcase
    end

endmodule

`default_nettype wire
